>>> hdl/pta_pkg.sv
// Shared types and constants for the packed tensor element access block.
// No dependencies; used by every module under hdl except pta_ram.
package pta_pkg;

	localparam int MAX_DIMS      = 4;
	localparam int INDEX_FIELDS  = 4;
	localparam int NDIM_LIM      = (MAX_DIMS < INDEX_FIELDS) ? MAX_DIMS : INDEX_FIELDS;
	localparam int DIM_W         = 2;
	localparam int STORE_BYTES   = 65536;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int LANES         = 4;
	localparam int LANE_W        = 2;
	localparam int ROW_W         = ADDR_W - LANE_W;
	localparam int ROWS          = STORE_BYTES / LANES;
	localparam int IDX_W         = 16;
	localparam int DSIZE_W       = 17;
	localparam int VALUE_W       = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 17;

	// Flat index and strides saturate here; anything at the cap is out of
	// range for every data type (binary reaches furthest, 8 per byte).
	localparam int FLAT_W        = ADDR_W + 4;
	localparam logic [FLAT_W-1:0] FLAT_CAP = FLAT_W'(1) << (ADDR_W + 3);

	typedef enum logic [2:0] {
		DT_F32     = 3'd0,
		DT_F16     = 3'd1,
		DT_BF16    = 3'd2,
		DT_INT8    = 3'd3,
		DT_UINT8   = 3'd4,
		DT_INT4    = 3'd5,
		DT_BINARY  = 3'd6,
		DT_INVALID = 3'd7
	} dtype_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_TYPE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	localparam logic [1:0] LAYOUT_ROW = 2'd0;
	localparam logic [1:0] LAYOUT_COL = 2'd1;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3  = 3'd6;

	typedef struct packed {
		dtype_t                                 data_type;
		logic [1:0]                             layout_mode;
		logic [2:0]                             num_dims;
		logic [INDEX_FIELDS-1:0][DSIZE_W-1:0]   dim_size;
	} cfg_t;

endpackage

>>> hdl/pta_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module pta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> hdl/pta_cfg_regs.sv
// Configuration register file: data type, layout, dimension count, extents.
// Depends on pta_pkg.
module pta_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pta_pkg::CFG_DATA_W-1:0] cfg_data,
	output pta_pkg::cfg_t                  cfg
);
	import pta_pkg::*;

	cfg_t cfg_q;
	logic [CFG_IDX_W-1:0] dim_off;

	assign cfg_ready = 1'b1;
	assign dim_off   = cfg_index - REG_DIM_SIZE_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.data_type   <= DT_F32;
			cfg_q.layout_mode <= LAYOUT_ROW;
			cfg_q.num_dims    <= 3'd1;
			for (int i = 0; i < INDEX_FIELDS; i++) begin
				cfg_q.dim_size[i] <= DSIZE_W'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index) inside
				REG_DATA_TYPE:   cfg_q.data_type   <= dtype_t'(cfg_data[2:0]);
				REG_LAYOUT_MODE: cfg_q.layout_mode <= cfg_data[1:0];
				REG_NUM_DIMS:    cfg_q.num_dims    <= cfg_data[2:0];
				[REG_DIM_SIZE_0:REG_DIM_SIZE_3]: begin
					cfg_q.dim_size[dim_off[DIM_W-1:0]] <= cfg_data[DSIZE_W-1:0];
				end
				default: ;  // index past the register list: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/pta_flat_index.sv
// Flat element index unit: one dimension per cycle, stride and index
// products registered each step. Depends on pta_pkg.
module pta_flat_index (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   go,
	input  pta_pkg::cfg_t                                          cfg,
	input  logic [pta_pkg::INDEX_FIELDS-1:0][pta_pkg::IDX_W-1:0]   idx,
	output logic                                                   done,
	output logic [pta_pkg::FLAT_W-1:0]                             flat
);
	import pta_pkg::*;

	localparam int TERM_W = IDX_W + FLAT_W;
	localparam int SUM_W  = TERM_W + 1;
	localparam int PROD_W = FLAT_W + DSIZE_W;

	logic              run_q, done_q, col_q;
	logic [DIM_W-1:0]  dim_q, left_q;
	logic [FLAT_W-1:0] stride_q, flat_q;

	logic [2:0]        n_dims;
	logic [TERM_W-1:0] term;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [FLAT_W-1:0] flat_next, stride_next;

	always_comb begin
		if (cfg.num_dims == 3'd0) begin
			n_dims = 3'd1;
		end else if (cfg.num_dims > 3'(NDIM_LIM)) begin
			n_dims = 3'(NDIM_LIM);
		end else begin
			n_dims = cfg.num_dims;
		end
	end

	// Row-major walks from the last dimension down, column-major from dim 0 up;
	// either way the next stride is this stride times this extent.
	always_comb begin
		term = {{FLAT_W{1'b0}}, idx[dim_q]} * {{IDX_W{1'b0}}, stride_q};
		sum  = {1'b0, term} + SUM_W'(flat_q);
		flat_next = (sum > SUM_W'(FLAT_CAP)) ? FLAT_CAP : sum[FLAT_W-1:0];
		prod = {{DSIZE_W{1'b0}}, stride_q} * {{FLAT_W{1'b0}}, cfg.dim_size[dim_q]};
		stride_next = (prod > PROD_W'(FLAT_CAP)) ? FLAT_CAP : prod[FLAT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && left_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			col_q    <= (cfg.layout_mode == LAYOUT_COL);
			dim_q    <= (cfg.layout_mode == LAYOUT_COL) ? '0 : DIM_W'(n_dims - 3'd1);
			left_q   <= DIM_W'(n_dims - 3'd1);
			stride_q <= FLAT_W'(1);
			flat_q   <= '0;
		end else if (run_q) begin
			flat_q   <= flat_next;
			stride_q <= stride_next;
			left_q   <= left_q - DIM_W'(1);
			dim_q    <= col_q ? dim_q + DIM_W'(1) : dim_q - DIM_W'(1);
		end
	end

	assign done = done_q;
	assign flat = flat_q;

endmodule

>>> hdl/packed_tensor_element_access.sv
// Top level: command sequencer, range check and byte-lane store access.
// Depends on pta_pkg, pta_cfg_regs, pta_flat_index, pta_ram.
//
//  channel  dir  transaction when         payload
//  command  in   start & !busy            operation, index_0..3, write_value
//  result   out  done (one cycle)         read_value, status
//  config   in   cfg_valid & cfg_ready    cfg_index, cfg_data
//
// One command at a time: the index unit takes the n dimensions in use (1..4)
// one dimension a cycle, then the store is read as the index state ends and,
// for writes, written back in the respond state. Errors skip the store access
// and report from the index state. The receiver cannot stall results.
// Reset clears control and configuration; store bytes are undefined until
// written and no clearing pass runs.
module packed_tensor_element_access (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           operation,
	input  logic [pta_pkg::IDX_W-1:0]      index_0,
	input  logic [pta_pkg::IDX_W-1:0]      index_1,
	input  logic [pta_pkg::IDX_W-1:0]      index_2,
	input  logic [pta_pkg::IDX_W-1:0]      index_3,
	input  logic [pta_pkg::VALUE_W-1:0]    write_value,
	output logic                           done,
	output logic [pta_pkg::VALUE_W-1:0]    read_value,
	output logic [1:0]                     status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pta_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pta_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_INDEX   = 3'b010,
		S_RESPOND = 3'b100
	} state_t;

	state_t state_q;
	cfg_t   cfg;

	logic                                 accept;
	logic                                 op_q;
	logic [VALUE_W-1:0]                   wv_q;
	logic [INDEX_FIELDS-1:0][IDX_W-1:0]   idx_q;

	logic              fi_done;
	logic [FLAT_W-1:0] flat;

	logic              in_range, bad_type;
	logic [ADDR_W-1:0] byte_addr;
	logic [ROW_W-1:0]  row_q;
	logic [LANE_W-1:0] lane_q;
	logic [2:0]        flat_lo_q;

	logic                          rd_en;
	logic [ROW_W-1:0]              mem_addr;
	logic [LANES-1:0]              lane_we;
	logic [LANES-1:0][7:0]         lane_wd;
	logic [LANES-1:0][7:0]         rd;
	logic [7:0]                    sel_byte, bit_mask;
	logic [VALUE_W-1:0]            rv;

	logic               done_q;
	logic [VALUE_W-1:0] read_value_q;
	status_t            status_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	pta_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pta_flat_index u_flat (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.cfg    (cfg),
		.idx    (idx_q),
		.done   (fi_done),
		.flat   (flat)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			wv_q     <= write_value;
			idx_q[0] <= index_0;
			idx_q[1] <= index_1;
			idx_q[2] <= index_2;
			idx_q[3] <= index_3;
		end
	end

	// Element placement and bounds; every byte of a legal element is in range
	// exactly when the flat index is below the per-type limit.
	always_comb begin
		bad_type  = 1'b0;
		in_range  = 1'b0;
		byte_addr = '0;
		unique case (cfg.data_type) inside
			DT_F32: begin
				in_range  = flat < FLAT_W'(STORE_BYTES / 4);
				byte_addr = {flat[ADDR_W-3:0], 2'b00};
			end
			DT_F16, DT_BF16: begin
				in_range  = flat < FLAT_W'(STORE_BYTES / 2);
				byte_addr = {flat[ADDR_W-2:0], 1'b0};
			end
			DT_INT8, DT_UINT8: begin
				in_range  = flat < FLAT_W'(STORE_BYTES);
				byte_addr = flat[ADDR_W-1:0];
			end
			DT_INT4: begin
				in_range  = flat < FLAT_W'(STORE_BYTES * 2);
				byte_addr = flat[ADDR_W:1];
			end
			DT_BINARY: begin
				in_range  = flat < FLAT_W'(STORE_BYTES * 8);
				byte_addr = flat[ADDR_W+2:3];
			end
			default: bad_type = 1'b1;
		endcase
	end

	assign rd_en = (state_q == S_INDEX) && fi_done && !bad_type && in_range;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			row_q     <= byte_addr[ADDR_W-1:LANE_W];
			lane_q    <= byte_addr[LANE_W-1:0];
			flat_lo_q <= flat[2:0];
		end
	end

	assign mem_addr = (state_q == S_RESPOND) ? row_q : byte_addr[ADDR_W-1:LANE_W];
	assign sel_byte = rd[lane_q];
	assign bit_mask = 8'h01 << flat_lo_q;

	always_comb begin
		rv = '0;
		unique case (cfg.data_type) inside
			DT_F32:            rv = {rd[3], rd[2], rd[1], rd[0]};
			DT_F16, DT_BF16:   rv = lane_q[1] ? VALUE_W'({rd[3], rd[2]})
			                                  : VALUE_W'({rd[1], rd[0]});
			DT_INT8, DT_UINT8: rv = VALUE_W'(sel_byte);
			DT_INT4:           rv = flat_lo_q[0] ? VALUE_W'(sel_byte[3:0])
			                                     : VALUE_W'(sel_byte[7:4]);
			DT_BINARY:         rv = VALUE_W'(sel_byte[flat_lo_q]);
			default:           rv = '0;
		endcase
	end

	// Write-back: full-width types overwrite their lanes, packed types merge
	// into the byte read in the previous cycle.
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			lane_we[k] = 1'b0;
			lane_wd[k] = wv_q[7:0];
			unique case (cfg.data_type) inside
				DT_F32: begin
					lane_we[k] = 1'b1;
					lane_wd[k] = wv_q[8*k +: 8];
				end
				DT_F16, DT_BF16: begin
					lane_we[k] = (lane_q[1] == 1'(k >> 1));
					lane_wd[k] = wv_q[8*(k & 1) +: 8];
				end
				DT_INT8, DT_UINT8: begin
					lane_we[k] = (lane_q == LANE_W'(k));
				end
				DT_INT4: begin
					lane_we[k] = (lane_q == LANE_W'(k));
					lane_wd[k] = flat_lo_q[0] ? {sel_byte[7:4], wv_q[3:0]}
					                          : {wv_q[3:0], sel_byte[3:0]};
				end
				DT_BINARY: begin
					lane_we[k] = (lane_q == LANE_W'(k));
					lane_wd[k] = wv_q[0] ? (sel_byte | bit_mask) : (sel_byte & ~bit_mask);
				end
				default: lane_we[k] = 1'b0;
			endcase
			lane_we[k] = lane_we[k] && (state_q == S_RESPOND) && (op_q == OP_WRITE);
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pta_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.en    (rd_en || lane_we[g]),
			.we    (lane_we[g]),
			.addr  (mem_addr),
			.wdata (lane_wd[g]),
			.rdata (rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_INDEX;
					end
				end
				S_INDEX: begin
					if (fi_done) begin
						if (rd_en) begin
							state_q <= S_RESPOND;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_RESPOND: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_INDEX && fi_done) begin
			read_value_q <= '0;
			if (bad_type) begin
				status_q <= ST_BAD_TYPE;
			end else if (!in_range) begin
				status_q <= ST_RANGE;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == S_RESPOND) begin
			read_value_q <= (op_q == OP_WRITE) ? '0 : rv;
			status_q     <= ST_OK;
		end
	end

	assign done       = done_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_INDEX))
		else $error("accepted command did not start index walk");

	a_finish_reports: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done_q)
		else $error("command finished without a result strobe");

	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && read_value_q != '0) |-> (status_q == ST_OK))
		else $error("nonzero read value with error status");

	a_write_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_we) |-> (state_q == S_RESPOND && op_q == OP_WRITE))
		else $error("store write outside write-back of a write command");

	a_index_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		fi_done |-> (state_q == S_INDEX))
		else $error("flat index completed outside index state");

endmodule

>>> verif/packed_tensor_element_access_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for packed_tensor_element_access: directed and random element
// reads and writes over several tensor shapes, layouts and data types, each result checked
// against a behavioral model of the stride math and the byte store. Depends on pta_pkg.
module packed_tensor_element_access_tb;
	import pta_pkg::*;

	localparam logic [1:0] LAYOUT_PACKED = 2'd2;
	localparam logic [1:0] LAYOUT_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint unsigned STRIDE_SAT = 64'd1 << 40;
	localparam longint unsigned STORE_SPAN = STORE_BYTES;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic                              op;
		logic [INDEX_FIELDS-1:0][IDX_W-1:0] idx;
		logic [VALUE_W-1:0]                wval;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] rv;
		status_t            st;
	} result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  operation = OP_READ;
	logic [IDX_W-1:0]      index_0 = '0;
	logic [IDX_W-1:0]      index_1 = '0;
	logic [IDX_W-1:0]      index_2 = '0;
	logic [IDX_W-1:0]      index_3 = '0;
	logic [VALUE_W-1:0]    write_value = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  done;
	logic [VALUE_W-1:0]    read_value;
	logic [1:0]            status;
	logic                  cfg_ready;

	// model copy of the configuration registers, reset values
	dtype_t             cfg_dtype = DT_F32;
	logic [1:0]         cfg_layout = LAYOUT_ROW;
	logic [2:0]         cfg_ndims = 3'd1;
	logic [DSIZE_W-1:0] cfg_dim [INDEX_FIELDS] = '{default: 17'd1};

	logic [7:0] tensor_bytes [STORE_BYTES];
	bit         plan_written [STORE_BYTES];

	cmd_t    pending_cmds [$];
	result_t pending_results [$];
	cmd_t    cur_cmd;
	int      send_idle_pct = 0;
	int      mismatch_cnt = 0;
	int      quiet_cycles = 0;

	packed_tensor_element_access i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.index_0     (index_0),
		.index_1     (index_1),
		.index_2     (index_2),
		.index_3     (index_3),
		.write_value (write_value),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned sat_mul(longint unsigned a, longint unsigned b);
		longint unsigned p;
		p = a * b;
		return (p > STRIDE_SAT) ? STRIDE_SAT : p;
	endfunction

	function automatic void locate_element(input cmd_t c, output longint unsigned flat,
			output longint unsigned addr, output int unsigned nbytes, output status_t st);
		longint unsigned stride [INDEX_FIELDS];
		int n;
		n = cfg_ndims;
		if (n < 1) n = 1;
		if (n > NDIM_LIM) n = NDIM_LIM;
		if (cfg_layout == LAYOUT_COL) begin
			stride[0] = 1;
			for (int i = 1; i < n; i++) stride[i] = sat_mul(stride[i-1], cfg_dim[i-1]);
		end else begin
			stride[n-1] = 1;
			for (int i = n - 1; i > 0; i--) stride[i-1] = sat_mul(stride[i], cfg_dim[i]);
		end
		flat = 0;
		for (int i = 0; i < n; i++) flat += c.idx[i] * stride[i];
		case (cfg_dtype)
			DT_F32: begin
				addr = flat * 4;
				nbytes = 4;
			end
			DT_F16, DT_BF16: begin
				addr = flat * 2;
				nbytes = 2;
			end
			DT_INT4: begin
				addr = flat >> 1;
				nbytes = 1;
			end
			DT_BINARY: begin
				addr = flat >> 3;
				nbytes = 1;
			end
			default: begin
				addr = flat;
				nbytes = 1;
			end
		endcase
		if (cfg_dtype == DT_INVALID) st = ST_BAD_TYPE;
		else if (addr >= STORE_SPAN || nbytes > STORE_SPAN - addr) st = ST_RANGE;
		else st = ST_OK;
	endfunction

	// Applies one element access to the model store and returns its result.
	function automatic result_t access_element(cmd_t c);
		longint unsigned flat, addr;
		int unsigned nb, sh;
		status_t st;
		result_t r;
		logic [7:0] b;
		bit hi;
		locate_element(c, flat, addr, nb, st);
		r.rv = '0;
		r.st = st;
		if (st != ST_OK) return r;
		b = tensor_bytes[addr];
		case (cfg_dtype)
			DT_INT4: begin
				hi = (flat % 2) == 0;
				if (c.op == OP_WRITE)
					tensor_bytes[addr] = hi ? {c.wval[3:0], b[3:0]} : {b[7:4], c.wval[3:0]};
				else
					r.rv = VALUE_W'(hi ? b[7:4] : b[3:0]);
			end
			DT_BINARY: begin
				sh = 32'(flat % 8);
				if (c.op == OP_WRITE) begin
					b[sh] = c.wval[0];
					tensor_bytes[addr] = b;
				end else begin
					r.rv = VALUE_W'(b[sh]);
				end
			end
			default: begin
				for (int k = 0; k < nb; k++) begin
					if (c.op == OP_WRITE) tensor_bytes[addr + k] = c.wval[8*k +: 8];
					else r.rv[8*k +: 8] = tensor_bytes[addr + k];
				end
			end
		endcase
		return r;
	endfunction

	// True when the access reads no store byte that is still unwritten at that point.
	function automatic bit safe_cmd(cmd_t c);
		longint unsigned flat, addr;
		int unsigned nb;
		status_t st;
		locate_element(c, flat, addr, nb, st);
		if (st != ST_OK) return 1'b1;
		if (c.op == OP_WRITE && cfg_dtype != DT_INT4 && cfg_dtype != DT_BINARY) return 1'b1;
		for (int k = 0; k < nb; k++) if (!plan_written[addr + k]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void queue_cmd(cmd_t c);
		longint unsigned flat, addr;
		int unsigned nb;
		status_t st;
		// element 0 always sits in the preloaded bytes
		if (!safe_cmd(c)) c.idx = '0;
		locate_element(c, flat, addr, nb, st);
		if (st == ST_OK && c.op == OP_WRITE)
			for (int k = 0; k < nb; k++) plan_written[addr + k] = 1'b1;
		pending_cmds.push_back(c);
	endfunction

	function automatic void push_cmd(logic op, logic [INDEX_FIELDS*IDX_W-1:0] idx,
			logic [VALUE_W-1:0] wv);
		cmd_t c;
		c.op = op;
		c.idx = idx;
		c.wval = wv;
		queue_cmd(c);
	endfunction

	function automatic logic [IDX_W-1:0] pick_coord(int d);
		int unsigned top;
		if (cfg_dim[d] > 17'd65536) top = 65535;
		else if (cfg_dim[d] == 0) top = 0;
		else top = cfg_dim[d] - 1;
		case ($urandom_range(9, 0))
			0: return '0;
			1: return '1;
			2, 3: return IDX_W'($urandom);
			default: return IDX_W'($urandom_range(top, 0));
		endcase
	endfunction

	function automatic void gen_random_cmd();
		cmd_t c;
		bit sub_byte;
		sub_byte = (cfg_dtype == DT_INT4 || cfg_dtype == DT_BINARY);
		c.op = ($urandom_range(1, 0) == 1) ? OP_WRITE : OP_READ;
		c.wval = $urandom;
		for (int t = 0; t < 64; t++) begin
			for (int d = 0; d < INDEX_FIELDS; d++) c.idx[d] = pick_coord(d);
			if (safe_cmd(c)) break;
			if (!sub_byte) begin
				// a whole-element write needs no prior contents
				c.op = OP_WRITE;
				break;
			end
		end
		queue_cmd(c);
	endfunction

	// checked on the falling edge so the driver's updates of the rising edge have settled
	task automatic wait_drained();
		while (pending_cmds.size() != 0 || start || pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DATA_TYPE: cfg_dtype = dtype_t'(data[2:0]);
			REG_LAYOUT_MODE: cfg_layout = data[1:0];
			REG_NUM_DIMS: cfg_ndims = data[2:0];
			default: begin
				if (idx >= REG_DIM_SIZE_0 && idx <= REG_DIM_SIZE_3)
					cfg_dim[idx - REG_DIM_SIZE_0] = data;
			end
		endcase
	endtask

	task automatic set_config(dtype_t dt, logic [1:0] lay, logic [2:0] nd,
			logic [CFG_DATA_W-1:0] d0, d1, d2, d3);
		wait_drained();
		write_reg(REG_DATA_TYPE, CFG_DATA_W'(dt));
		write_reg(REG_LAYOUT_MODE, CFG_DATA_W'(lay));
		write_reg(REG_NUM_DIMS, CFG_DATA_W'(nd));
		write_reg(REG_DIM_SIZE_0, d0);
		write_reg(REG_DIM_SIZE_0 + 3'd1, d1);
		write_reg(REG_DIM_SIZE_0 + 3'd2, d2);
		write_reg(REG_DIM_SIZE_3, d3);
	endtask

	task automatic run_phase(dtype_t dt, logic [1:0] lay, logic [2:0] nd,
			logic [CFG_DATA_W-1:0] d0, d1, d2, d3, int count, int idle_pct);
		set_config(dt, lay, nd, d0, d1, d2, d3);
		send_idle_pct = idle_pct;
		repeat (count) gen_random_cmd();
	endtask

	// Command driver: one expected result per accepted command transaction.
	always @(posedge clk or negedge arst_n) begin : drive_cmd
		if (!arst_n) begin
			start <= 1'b0;
			operation <= OP_READ;
			index_0 <= '0;
			index_1 <= '0;
			index_2 <= '0;
			index_3 <= '0;
			write_value <= '0;
		end else begin
			if (start && !busy) pending_results.push_back(access_element(cur_cmd));
			if (!(start && busy)) begin
				if (pending_cmds.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					cur_cmd = pending_cmds.pop_front();
					start <= 1'b1;
					operation <= cur_cmd.op;
					index_0 <= cur_cmd.idx[0];
					index_1 <= cur_cmd.idx[1];
					index_2 <= cur_cmd.idx[2];
					index_3 <= cur_cmd.idx[3];
					write_value <= cur_cmd.wval;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("unexpected result: read_value %h status %0d", read_value, status);
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.rv || status !== want.st) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("mismatch at %0t: read_value %h status %0d, expected %h %0d",
							$time, read_value, status, want.rv, want.st);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// preload bytes 0..255 so reads and sub-byte updates only ever see written data
		set_config(DT_UINT8, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		for (int i = 0; i < 256; i++) push_cmd(OP_WRITE, 64'(i), $urandom);

		push_cmd(OP_WRITE, {4{16'hFFFF}}, 32'hFFFF_FFFF);
		push_cmd(OP_READ, {4{16'hFFFF}}, 32'h0);
		push_cmd(OP_WRITE, 64'h0, 32'h0);
		push_cmd(OP_READ, 64'h0, 32'hFFFF_FFFF);

		set_config(DT_F32, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_WRITE, 64'h3FFF, 32'hA5C3_0FF0);
		push_cmd(OP_READ, 64'h3FFF, 32'h0);
		push_cmd(OP_WRITE, 64'h4000, 32'h1234_5678);
		push_cmd(OP_READ, 64'hFFFF, 32'h0);
		push_cmd(OP_READ, 64'h0, 32'h0);

		set_config(DT_F16, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_WRITE, 64'h7FFF, 32'h1234_BEEF);
		push_cmd(OP_READ, 64'h7FFF, 32'h0);
		push_cmd(OP_READ, 64'h8000, 32'h0);

		set_config(DT_BF16, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_READ, 64'h1, 32'h0);

		set_config(DT_INT8, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_READ, 64'h5, 32'h0);

		// nibble updates: even index lands in the high half
		set_config(DT_INT4, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_WRITE, 64'h2, 32'hFFFF_FFF9);
		push_cmd(OP_READ, 64'h2, 32'h0);
		push_cmd(OP_WRITE, 64'h3, 32'h6);
		push_cmd(OP_READ, 64'h3, 32'h0);
		push_cmd(OP_READ, 64'h1FF, 32'h0);

		set_config(DT_BINARY, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1);
		push_cmd(OP_WRITE, 64'h9, 32'h1);
		push_cmd(OP_READ, 64'h9, 32'h0);
		push_cmd(OP_WRITE, 64'h7FF, 32'h0);
		push_cmd(OP_READ, 64'h7FF, 32'h0);

		set_config(DT_INVALID, LAYOUT_ROW, 3'd1, 17'd1, 17'd1, 17'd1, 17'd1);
		write_reg(REG_UNUSED, '1);
		push_cmd(OP_READ, {4{16'hFFFF}}, 32'h0);
		push_cmd(OP_WRITE, 64'h0, 32'hFFFF_FFFF);

		// sender idle 0, 10 or 66 percent by phase; results cannot be held off
		run_phase(DT_F32, LAYOUT_ROW, 3'd2, 17'd8, 17'd16, 17'd1, 17'd1, 80, 0);
		run_phase(DT_INT4, LAYOUT_COL, 3'd3, 17'd4, 17'd4, 17'd8, 17'd1, 80, 66);
		run_phase(DT_BINARY, LAYOUT_PACKED, 3'd4, 17'd2, 17'd4, 17'd4, 17'd8, 80, 0);
		run_phase(DT_F16, LAYOUT_SPARE, 3'd0, 17'h10000, 17'd7, 17'd9, 17'd3, 80, 10);
		run_phase(DT_INT8, LAYOUT_COL, 3'd7, 17'd0, 17'd3, 17'h1FFFF, 17'd5, 60, 66);
		run_phase(DT_UINT8, LAYOUT_ROW, 3'd4, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
			60, 0);
		run_phase(DT_INVALID, LAYOUT_ROW, 3'd2, 17'd16, 17'd16, 17'd1, 17'd1, 40, 10);
		run_phase(DT_BF16, LAYOUT_COL, 3'd2, 17'd64, 17'd1024, 17'd1, 17'd1, 80, 0);
		run_phase(DT_INT4, LAYOUT_ROW, 3'd1, 17'd512, 17'd2, 17'd2, 17'd2, 80, 66);
		run_phase(DT_BINARY, LAYOUT_COL, 3'd2, 17'd64, 17'd32, 17'd1, 17'd1, 80, 10);
		run_phase(DT_F32, LAYOUT_COL, 3'd3, 17'd4, 17'd4, 17'd4, 17'd1, 80, 66);
		run_phase(DT_UINT8, LAYOUT_ROW, 3'd1, 17'h10000, 17'd1, 17'd1, 17'd1, 60, 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
